// ===== sv/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha1md_pkg;

  localparam int unsigned BlockBits = 512;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [5:0]  PosLast   = 6'd63;
  localparam logic [5:0]  PosLen    = 6'd56;
  localparam logic [6:0]  RoundLast = 7'd79;
  localparam logic [2:0]  WordLast  = 3'd4;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_EMIT
  } state_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      shift;
    byte_src_t src;
    logic      round;
    logic      add_chain;
    logic      restart;
    logic [2:0] word_index;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
  } dp_status_t;

endpackage

// ===== sv/sha1_message_digest.sv =====
// SHA-1 message digest: one message byte per beat, five digest words out.
// The beat that fills a 64-byte block starts a compression (80 rounds,
// then the chaining add). The final beat is followed by padding bytes up
// to the block end, a pause before the length bytes, one or two
// compressions, then five output beats.
// One item at a time. Synchronous reset loads the initial chaining words.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1md_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .word_index     (word_index),
    .last_word      (last_word),
    .status         (status),
    .cmd            (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word)
  );

endmodule

// ===== sv/sha1md_dp.sv =====
// Datapath of the SHA-1 block: block buffer and message schedule, round
// registers, chaining words and bit count. Depends on sha1md_pkg.
module sha1md_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1md_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output sha1md_pkg::dp_status_t status,
  output logic [31:0]          digest_word
);
  import sha1md_pkg::*;

  logic [BlockBits-1:0] blk;
  logic [31:0] a, b, c, d, e;
  logic [31:0] h0, h1, h2, h3, h4;
  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic [6:0]  round_count;

  logic [7:0]  byte_in;
  logic [2:0]  len_sel;
  logic [31:0] w0, w2, w8, w13, w_new_pre, w_new;
  logic [31:0] f, kk, t;

  // Schedule taps: word j sits at the top of the buffer, oldest first.
  assign w0  = blk[BlockBits-1      -: 32];
  assign w2  = blk[BlockBits-1-64   -: 32];
  assign w8  = blk[BlockBits-1-256  -: 32];
  assign w13 = blk[BlockBits-1-416  -: 32];
  assign w_new_pre = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_new_pre[30:0], w_new_pre[31]};

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_sel = 3'd7 - pos[2:0];

  always_comb begin
    unique case (cmd.src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PadByte;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = bit_length[{len_sel, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  // Round function and constant by round group.
  always_comb begin
    if (round_count < 7'd20) begin
      f  = (b & c) | (~b & d);
      kk = K0;
    end else if (round_count < 7'd40) begin
      f  = b ^ c ^ d;
      kk = K1;
    end else if (round_count < 7'd60) begin
      f  = (b & c) | (b & d) | (c & d);
      kk = K2;
    end else begin
      f  = b ^ c ^ d;
      kk = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + w0 + kk;

  // Block buffer: bytes and schedule words both shift in at the bottom.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[BlockBits-9:0], byte_in};
    end else if (cmd.round) begin
      blk <= {blk[BlockBits-33:0], w_new};
    end
  end

  // Round registers; a full block loads them from the chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0;
    end else if (cmd.shift && pos == PosLast) begin
      a <= h0; b <= h1; c <= h2; d <= h3; e <= h4;
    end else if (cmd.round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  // Round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= '0;
    end else if (cmd.round) begin
      round_count <= (round_count == RoundLast) ? 7'd0 : round_count + 7'd1;
    end
  end

  // Chaining words, byte position and bit count.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      h0 <= H0; h1 <= H1; h2 <= H2; h3 <= H3; h4 <= H4;
      pos        <= '0;
      bit_length <= '0;
    end else begin
      if (cmd.add_chain) begin
        h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d; h4 <= h4 + e;
      end
      if (cmd.shift) begin
        pos <= pos + 6'd1;
        if (cmd.src == SRC_DATA) begin
          bit_length <= bit_length + 64'd8;
        end
      end
    end
  end

  // Digest words leave in reversed order: index k carries word 4-k.
  always_comb begin
    unique case (cmd.word_index)
      3'd0:    digest_word = h4;
      3'd1:    digest_word = h3;
      3'd2:    digest_word = h2;
      3'd3:    digest_word = h1;
      3'd4:    digest_word = h0;
      default: digest_word = h0;
    endcase
  end

  assign status.pos        = pos;
  assign status.round_last = (round_count == RoundLast);

endmodule

// ===== sv/sha1md_ctrl.sv =====
// Controller of the SHA-1 block: input and output handshakes, padding
// sequence and compression start. Depends on sha1md_pkg.
module sha1md_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   byte_present,
  input  logic                   end_of_message,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [2:0]             word_index,
  output logic                   last_word,
  input  sha1md_pkg::dp_status_t status,
  output sha1md_pkg::dp_cmd_t    cmd
);
  import sha1md_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;
  logic [2:0] word_count, word_count_next;
  logic in_beat, out_beat, full;

  assign in_beat  = item_valid && item_ready;
  assign out_beat = result_valid && result_ready;
  assign full     = (status.pos == PosLast);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret        <= ST_IDLE;
      word_count <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      word_count <= word_count_next;
    end
  end

  // Next state, return state after a compression, output word count.
  always_comb begin
    state_next      = state;
    ret_next        = ret;
    word_count_next = word_count;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (byte_present && full) begin
            state_next = ST_ROUND;
            ret_next   = end_of_message ? ST_PAD : ST_IDLE;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (status.round_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ret;
      end
      ST_PAD: begin
        if (full) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (status.pos == PosLen) begin
          state_next = ST_LEN;
        end else if (full) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (full) begin
          state_next = ST_ROUND;
          ret_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          if (word_count == WordLast) begin
            state_next      = ST_IDLE;
            word_count_next = '0;
          end else begin
            word_count_next = word_count + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshakes and datapath commands.
  always_comb begin
    item_ready     = (state == ST_IDLE);
    result_valid   = (state == ST_EMIT);
    word_index     = word_count;
    last_word      = (word_count == WordLast);
    cmd            = '0;
    cmd.src        = SRC_DATA;
    cmd.word_index = word_count;
    unique case (state)
      ST_IDLE: begin
        cmd.shift = in_beat && byte_present;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_FINISH: begin
        cmd.add_chain = 1'b1;
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        cmd.src   = SRC_PAD;
      end
      ST_ZERO: begin
        cmd.shift = (status.pos != PosLen);
        cmd.src   = SRC_ZERO;
      end
      ST_LEN: begin
        cmd.shift = 1'b1;
        cmd.src   = SRC_LEN;
      end
      ST_EMIT: begin
        cmd.restart = out_beat && (word_count == WordLast);
      end
      default: begin
        cmd.shift = 1'b0;
      end
    endcase
  end

endmodule
